// ----- sv/clm_pkg.sv -----
// ----------------------------------------------------------------------------
// clm_pkg: shared types and constants of the circle/line intersection block
// Payload structs, pipeline word layouts and the widths derived from the
// coordinate width.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int CoordBits = 16;

  // Derived widths. Centered coordinates and differences need one extra bit.
  localparam int TxW   = CoordBits + 1;
  localparam int Dr2W  = 2 * CoordBits + 1;
  localparam int DW    = 2 * CoordBits + 2;
  localparam int RrW   = 2 * CoordBits - 2;
  localparam int DdW   = 4 * CoordBits + 2;
  localparam int DiscW = 4 * CoordBits + 3;
  localparam int RadW  = 4 * CoordBits;
  localparam int SqW   = 2 * CoordBits;
  localparam int RemW  = 2 * CoordBits + 1;
  localparam int NumW  = 3 * CoordBits + 3;
  localparam int MagW  = 3 * CoordBits + 2;
  localparam int QuoW  = CoordBits + 1;
  localparam int QsW   = CoordBits + 3;
  localparam int SumW  = CoordBits + 3;
  localparam int NumLanes = 4;

  localparam int AddrW = 3;
  localparam logic [AddrW-1:0] AddrCenterX = 3'd0;
  localparam logic [AddrW-1:0] AddrCenterY = 3'd4;

  typedef enum logic [1:0] {
    LaneXP,
    LaneXM,
    LaneYP,
    LaneYM
  } lane_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_x;
    logic signed [CoordBits-1:0] first_y;
    logic signed [CoordBits-1:0] second_x;
    logic signed [CoordBits-1:0] second_y;
    logic [CoordBits-2:0]        radius;
  } in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic                        valid_res;
  } out_t;

  // Context that rides along the square root chain.
  typedef struct packed {
    logic              ok;
    logic              y1pos;
    logic signed [DW-1:0]  d;
    logic signed [TxW-1:0] dx;
    logic signed [TxW-1:0] dy;
    logic [Dr2W-1:0]   dr2;
  } side_t;

  typedef struct packed {
    logic [RadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [SqW-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic            neg;
    logic            big;
    logic [MagW-1:0] rem;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic            ok;
    logic            y1pos;
    logic [Dr2W-1:0] dr2;
  } dctx_t;

endpackage

// ----- sv/circle_line_intersection.sv -----
// ----------------------------------------------------------------------------
// circle_line_intersection: pipelined circle/line intersection
// Intersects the line through two points with a circle around a configured
// center and returns one chosen intersection point per request.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid_i/in_ready_o) carries two points
// and a radius. The circle center is held in two APB registers, center x at
// address 0 and center y at address 4; write them only while the pipeline is
// empty. Each request yields exactly one result on the output channel
// (out_valid_o/out_ready_i), with valid_res low and zero coordinates when the
// line misses the circle or the two points coincide.
// Requests pass the front stages (centering, products, length and determinant,
// R^2*dr^2 and D^2, discriminant), the square root chain, the numerator
// product, root and magnitude stages, the divider chain and the output
// register. A new request is taken every cycle unless the receiver stalls
// with a result waiting: then the whole pipeline holds and in_ready_o drops;
// it rises as soon as the result is taken. Reset empties the pipeline and
// clears both center registers.
// ----------------------------------------------------------------------------
module circle_line_intersection (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  clm_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output clm_pkg::out_t        out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [clm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int N     = clm_pkg::CoordBits;
  localparam int TxW   = clm_pkg::TxW;
  localparam int Dr2W  = clm_pkg::Dr2W;
  localparam int DW    = clm_pkg::DW;
  localparam int RrW   = clm_pkg::RrW;
  localparam int DdW   = clm_pkg::DdW;
  localparam int DiscW = clm_pkg::DiscW;
  localparam int RadW  = clm_pkg::RadW;
  localparam int SqW   = clm_pkg::SqW;
  localparam int NumW  = clm_pkg::NumW;
  localparam int MagW  = clm_pkg::MagW;
  localparam int QuoW  = clm_pkg::QuoW;
  localparam int QsW   = clm_pkg::QsW;
  localparam int SumW  = clm_pkg::SumW;
  localparam int NumLanes = clm_pkg::NumLanes;
  localparam int XaW   = DW + TxW;
  localparam int XbW   = TxW + SqW + 1;
  localparam int YbW   = TxW + SqW;

  // ---------------------------------------------------------------- config
  logic signed [N-1:0] cx_q;
  logic signed [N-1:0] cy_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        clm_pkg::AddrCenterX: cx_q <= pwdata[N-1:0];
        clm_pkg::AddrCenterY: cy_q <= pwdata[N-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      clm_pkg::AddrCenterX: prdata = 32'(cx_q);
      clm_pkg::AddrCenterY: prdata = 32'(cy_q);
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------ pipeline control
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: shift the points so the center is the origin.
  logic                  s1_v_q;
  logic signed [TxW-1:0] tx1_q, ty1_q, tx2_q, ty2_q, dx1_q, dy1_q;
  logic [N-2:0]          r1_q;
  logic                  y1pos1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx1_q    <= TxW'(in_data_i.first_x) - TxW'(cx_q);
      ty1_q    <= TxW'(in_data_i.first_y) - TxW'(cy_q);
      tx2_q    <= TxW'(in_data_i.second_x) - TxW'(cx_q);
      ty2_q    <= TxW'(in_data_i.second_y) - TxW'(cy_q);
      dx1_q    <= TxW'(in_data_i.second_x) - TxW'(in_data_i.first_x);
      dy1_q    <= TxW'(in_data_i.second_y) - TxW'(in_data_i.first_y);
      r1_q     <= in_data_i.radius;
      y1pos1_q <= !in_data_i.first_y[N-1] && (in_data_i.first_y != '0);
    end
  end

  // Stage 2: squares and cross products.
  logic                      s2_v_q;
  logic signed [2*TxW-1:0]   pxx_q, pyy_q, pa_q, pb_q;
  logic [RrW-1:0]            rr2_q;
  logic signed [TxW-1:0]     dx2_q, dy2_q;
  logic                      y1pos2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxx_q    <= (2*TxW)'(dx1_q) * (2*TxW)'(dx1_q);
      pyy_q    <= (2*TxW)'(dy1_q) * (2*TxW)'(dy1_q);
      pa_q     <= (2*TxW)'(tx1_q) * (2*TxW)'(ty2_q);
      pb_q     <= (2*TxW)'(tx2_q) * (2*TxW)'(ty1_q);
      rr2_q    <= RrW'(r1_q) * RrW'(r1_q);
      dx2_q    <= dx1_q;
      dy2_q    <= dy1_q;
      y1pos2_q <= y1pos1_q;
    end
  end

  // Stage 3: squared length and determinant.
  logic                    s3_v_q;
  logic signed [2*TxW-1:0] len_sum;
  logic [Dr2W-1:0]         dr2_3_q;
  logic signed [DW-1:0]    d3_q;
  logic [RrW-1:0]          rr3_q;
  logic signed [TxW-1:0]   dx3_q, dy3_q;
  logic                    y1pos3_q;

  assign len_sum = pxx_q + pyy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr2_3_q  <= len_sum[Dr2W-1:0];
      d3_q     <= pa_q - pb_q;
      rr3_q    <= rr2_q;
      dx3_q    <= dx2_q;
      dy3_q    <= dy2_q;
      y1pos3_q <= y1pos2_q;
    end
  end

  // Stage 4: R^2 * dr^2 and D^2.
  logic                   s4_v_q;
  logic signed [2*DW-1:0] dd_full;
  logic [RrW+Dr2W-1:0]    rrdr_q;
  logic [DdW-1:0]         dd_q;
  logic [Dr2W-1:0]        dr2_4_q;
  logic signed [DW-1:0]   d4_q;
  logic signed [TxW-1:0]  dx4_q, dy4_q;
  logic                   y1pos4_q;

  assign dd_full = (2*DW)'(d3_q) * (2*DW)'(d3_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rrdr_q   <= (RrW+Dr2W)'(rr3_q) * (RrW+Dr2W)'(dr2_3_q);
      dd_q     <= dd_full[DdW-1:0];
      dr2_4_q  <= dr2_3_q;
      d4_q     <= d3_q;
      dx4_q    <= dx3_q;
      dy4_q    <= dy3_q;
      y1pos4_q <= y1pos3_q;
    end
  end

  // Stage 5: discriminant; a negative one or a zero length marks a miss.
  logic [DiscW-1:0] disc;
  logic             s5_v_q;
  clm_pkg::sq_t     sq_c   [SqW+1];
  clm_pkg::side_t   side_c [SqW+1];
  logic             sv_c   [SqW+1];

  assign disc = DiscW'(rrdr_q) - DiscW'(dd_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_c[0].rad     <= disc[RadW-1:0];
      sq_c[0].rem     <= '0;
      sq_c[0].root    <= '0;
      side_c[0].ok    <= !disc[DiscW-1] && (dr2_4_q != '0);
      side_c[0].y1pos <= y1pos4_q;
      side_c[0].d     <= d4_q;
      side_c[0].dx    <= dx4_q;
      side_c[0].dy    <= dy4_q;
      side_c[0].dr2   <= dr2_4_q;
    end
  end

  assign sv_c[0] = s5_v_q;

  for (genvar i = 0; i < SqW; i++) begin : g_sqrt
    clm_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv_c[i]),
      .sq_i    (sq_c[i]),
      .side_i  (side_c[i]),
      .valid_o (sv_c[i+1]),
      .sq_o    (sq_c[i+1]),
      .side_o  (side_c[i+1])
    );
  end

  // Stage M: numerator products.
  clm_pkg::side_t        sm;
  logic [SqW-1:0]        root;
  logic signed [TxW-1:0] sdx;
  logic [TxW-1:0]        ady;
  logic signed [SqW:0]   s_sg;
  logic                  sm_v_q;
  logic signed [XaW-1:0] xa_q, yd_q;
  logic signed [XbW-1:0] xb_q;
  logic [YbW-1:0]        yb_q;
  clm_pkg::dctx_t        ctx_m_q;

  always_comb begin
    sm   = side_c[SqW];
    root = sq_c[SqW].root;
    sdx  = sm.dy[TxW-1] ? -sm.dx : sm.dx;
    ady  = sm.dy[TxW-1] ? TxW'(-sm.dy) : TxW'(sm.dy);
    s_sg = $signed({1'b0, root});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xa_q          <= XaW'(sm.d) * XaW'(sm.dy);
      xb_q          <= XbW'(sdx) * XbW'(s_sg);
      yd_q          <= XaW'(sm.d) * XaW'(sm.dx);
      yb_q          <= YbW'(ady) * YbW'(root);
      ctx_m_q.ok    <= sm.ok;
      ctx_m_q.y1pos <= sm.y1pos;
      ctx_m_q.dr2   <= sm.dr2;
    end
  end

  // Stage A: both roots of both coordinates.
  logic                   sa_v_q;
  logic signed [NumW-1:0] num_q [NumLanes];
  clm_pkg::dctx_t         ctx_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[clm_pkg::LaneXP] <= NumW'(xa_q) + NumW'(xb_q);
      num_q[clm_pkg::LaneXM] <= NumW'(xa_q) - NumW'(xb_q);
      num_q[clm_pkg::LaneYP] <= NumW'(yb_q) - NumW'(yd_q);
      num_q[clm_pkg::LaneYM] <= -NumW'(yd_q) - NumW'(yb_q);
      ctx_a_q                <= ctx_m_q;
    end
  end

  // Stage B: magnitudes and an early flag for quotients beyond the range.
  logic                   sb_v_q;
  logic [NumW-1:0]        mag_full [NumLanes];
  logic [MagW-1:0]        big_lim;
  clm_pkg::lane_t [NumLanes-1:0] lanes_c [QuoW+1];
  clm_pkg::dctx_t         dctx_c [QuoW+1];
  logic                   dv_c   [QuoW+1];

  always_comb begin
    big_lim = {ctx_a_q.dr2, QuoW'(0)};
    for (int j = 0; j < NumLanes; j++) begin
      mag_full[j] = num_q[j][NumW-1] ? NumW'(-num_q[j]) : NumW'(num_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < NumLanes; j++) begin
        lanes_c[0][j].neg <= num_q[j][NumW-1];
        lanes_c[0][j].big <= mag_full[j][MagW-1:0] >= big_lim;
        lanes_c[0][j].rem <= mag_full[j][MagW-1:0];
        lanes_c[0][j].quo <= '0;
      end
      dctx_c[0] <= ctx_a_q;
    end
  end

  assign dv_c[0] = sb_v_q;

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    clm_div_cell #(
      .Shift (QuoW - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_c[i]),
      .dctx_i  (dctx_c[i]),
      .lanes_i (lanes_c[i]),
      .valid_o (dv_c[i+1]),
      .dctx_o  (dctx_c[i+1]),
      .lanes_o (lanes_c[i+1])
    );
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      sm_v_q <= 1'b0;
      sa_v_q <= 1'b0;
      sb_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      sm_v_q <= sv_c[SqW];
      sa_v_q <= sm_v_q;
      sb_v_q <= sa_v_q;
    end
  end

  // Output: root choice, center added back, saturation.
  function automatic logic signed [N-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [N-1:0] res;
    if (v[SumW-1:N-1] == '0 || v[SumW-1:N-1] == '1) begin
      res = v[N-1:0];
    end else if (v[SumW-1]) begin
      res = {1'b1, {(N-1){1'b0}}};
    end else begin
      res = {1'b0, {(N-1){1'b1}}};
    end
    return res;
  endfunction

  clm_pkg::lane_t [NumLanes-1:0] fl;
  clm_pkg::dctx_t        fc;
  logic [QuoW:0]         qmag [NumLanes];
  logic signed [QsW-1:0] qs   [NumLanes];
  logic signed [QsW-1:0] xsel, ysel;
  logic                  y_pos, y_neg, use_ym;
  clm_pkg::out_t         out_d;
  clm_pkg::out_t         out_data_q;

  always_comb begin
    fl = lanes_c[QuoW];
    fc = dctx_c[QuoW];
    for (int j = 0; j < NumLanes; j++) begin
      qmag[j] = fl[j].big ? (QuoW+1)'(1) << QuoW : (QuoW+1)'(fl[j].quo);
      qs[j]   = fl[j].neg ? -$signed({1'b0, qmag[j]}) : $signed({1'b0, qmag[j]});
    end
    xsel   = qs[clm_pkg::LaneXP][QsW-1] ? qs[clm_pkg::LaneXM] : qs[clm_pkg::LaneXP];
    y_neg  = qs[clm_pkg::LaneYP][QsW-1];
    y_pos  = !qs[clm_pkg::LaneYP][QsW-1] && (qs[clm_pkg::LaneYP] != '0);
    use_ym = (fc.y1pos && y_neg) || (!fc.y1pos && y_pos);
    ysel   = use_ym ? qs[clm_pkg::LaneYM] : qs[clm_pkg::LaneYP];
    if (fc.ok) begin
      out_d.out_x     = sat_coord(SumW'(xsel) + SumW'(cx_q));
      out_d.out_y     = sat_coord(SumW'(ysel) + SumW'(cy_q));
      out_d.valid_res = 1'b1;
    end else begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_c[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/clm_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// clm_sqrt_cell: one digit of the integer square root chain
// Brings down two radicand bits, tries the next root bit and passes the
// partial root, remainder and context to the next cell.
// ----------------------------------------------------------------------------
module clm_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  clm_pkg::sq_t   sq_i,
  input  clm_pkg::side_t side_i,
  output logic           valid_o,
  output clm_pkg::sq_t   sq_o,
  output clm_pkg::side_t side_o
);

  localparam int RemW = clm_pkg::RemW;
  localparam int RadW = clm_pkg::RadW;
  localparam int SqW  = clm_pkg::SqW;
  localparam int CurW = RemW + 2;

  logic [CurW-1:0] cur;
  logic [CurW-1:0] trial;
  logic [CurW-1:0] diff;
  logic            take;
  clm_pkg::sq_t    sq_d;
  clm_pkg::sq_t    sq_q;
  clm_pkg::side_t  side_q;
  logic            valid_q;

  always_comb begin
    cur   = {sq_i.rem, sq_i.rad[RadW-1 -: 2]};
    trial = CurW'({sq_i.root, 2'b01});
    diff  = cur - trial;
    take  = (cur >= trial);
    sq_d.rad  = sq_i.rad << 2;
    sq_d.rem  = take ? diff[RemW-1:0] : cur[RemW-1:0];
    sq_d.root = {sq_i.root[SqW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign side_o  = side_q;

endmodule

// ----- sv/clm_div_cell.sv -----
// ----------------------------------------------------------------------------
// clm_div_cell: one quotient bit of the four-lane restoring divider
// Each lane compares its remainder with the shifted divisor, subtracts on a
// hit and sets the quotient bit that this cell owns.
// ----------------------------------------------------------------------------
module clm_div_cell #(
  parameter int Shift = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  clm_pkg::dctx_t dctx_i,
  input  clm_pkg::lane_t [clm_pkg::NumLanes-1:0] lanes_i,
  output logic           valid_o,
  output clm_pkg::dctx_t dctx_o,
  output clm_pkg::lane_t [clm_pkg::NumLanes-1:0] lanes_o
);

  localparam int MagW = clm_pkg::MagW;
  localparam int NumLanes = clm_pkg::NumLanes;

  logic [MagW-1:0] dsr;
  clm_pkg::lane_t [NumLanes-1:0] lanes_d;
  clm_pkg::lane_t [NumLanes-1:0] lanes_q;
  clm_pkg::dctx_t dctx_q;
  logic           valid_q;

  always_comb begin
    dsr     = MagW'(dctx_i.dr2) << Shift;
    lanes_d = lanes_i;
    for (int j = 0; j < NumLanes; j++) begin
      if (lanes_i[j].rem >= dsr) begin
        lanes_d[j].rem        = lanes_i[j].rem - dsr;
        lanes_d[j].quo[Shift] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
      dctx_q  <= dctx_i;
    end
  end

  assign valid_o = valid_q;
  assign dctx_o  = dctx_q;
  assign lanes_o = lanes_q;

endmodule

// ----- sv/clm_checker.sv -----
// ----------------------------------------------------------------------------
// clm_checker: port-level checks for the circle/line intersection block
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module clm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input clm_pkg::out_t out_data_i
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // The pipeline only holds back requests while a result waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("request ready does not follow the output stall");

  // A miss reports the origin.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.valid_res |->
      out_data_i.out_x == '0 && out_data_i.out_y == '0)
    else $error("missed intersection with nonzero coordinates");

endmodule

bind circle_line_intersection clm_checker u_clm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Circle/line intersection testbench
// Drives line requests through the valid/ready input channel and checks every
// result against an in-bench integer model of the intersection or a listed
// expected point. The circle center is reprogrammed over APB between phases,
// and each phase sets a mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef clm_pkg::in_t  in_t;
  typedef clm_pkg::out_t out_t;
  typedef logic signed [129:0] wide_t;

  localparam int CoordBits     = clm_pkg::CoordBits;
  localparam int AddrW         = clm_pkg::AddrW;
  localparam int LatencyCycles = 3 * CoordBits + 10;
  localparam int CycleLimit    = 400000;
  localparam int ItemsPerPhase = 170;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic signed [CoordBits-1:0] cen_x = '0;
  logic signed [CoordBits-1:0] cen_y = '0;
  out_t expected_points[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  circle_line_intersection dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Truncating division with the quotient magnitude clamped to 2^40.
  function automatic wide_t clamp_div(wide_t n, wide_t d);
    wide_t q;
    wide_t lim;
    lim = wide_t'(1) <<< 40;
    q = n / d;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic logic signed [CoordBits-1:0] sat_coord(wide_t v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CoordBits-1:0];
  endfunction

  function automatic out_t intersect_point(in_t q);
    wide_t tx1, ty1, tx2, ty2, dx, dy, dr2, d, disc, rr, s, c, sdx, ady, x, y;
    wide_t fy;
    out_t o;
    o = '0;
    fy = $signed(q.first_y);
    tx1 = $signed(q.first_x);
    tx1 = tx1 - $signed(cen_x);
    ty1 = fy - $signed(cen_y);
    tx2 = $signed(q.second_x);
    tx2 = tx2 - $signed(cen_x);
    ty2 = $signed(q.second_y);
    ty2 = ty2 - $signed(cen_y);
    rr = $signed({1'b0, q.radius});
    dx = tx2 - tx1;
    dy = ty2 - ty1;
    dr2 = dx * dx + dy * dy;
    d = tx1 * ty2 - tx2 * ty1;
    disc = rr * rr * dr2 - d * d;
    if (dr2 == 0 || disc < 0) return o;
    s = 0;
    for (int b = 63; b >= 0; b--) begin
      c = s | (wide_t'(1) <<< b);
      if (c * c <= disc) s = c;
    end
    sdx = (dy < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    x = clamp_div(d * dy + sdx * s, dr2);
    if (x < 0) x = clamp_div(d * dy - sdx * s, dr2);
    y = clamp_div(-d * dx + ady * s, dr2);
    if ((fy > 0 && y < 0) || (fy <= 0 && y > 0)) y = clamp_div(-d * dx - ady * s, dr2);
    o.out_x = sat_coord(x + $signed(cen_x));
    o.out_y = sat_coord(y + $signed(cen_y));
    o.valid_res = 1'b1;
    return o;
  endfunction

  // Timeout watchdog and receiver stalls.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = expected_points.pop_front();
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.valid_res !== want.valid_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
                     want.out_x, want.out_y, want.valid_res,
                     out_data.out_x, out_data.out_y, out_data.valid_res);
        end
      end
    end
  end

  task automatic send_request(in_t v, bit typed, out_t want);
    out_t exp_pt;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk_i); while (!in_ready);
    exp_pt = typed ? want : intersect_point(v);
    expected_points = {expected_points, exp_pt};
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
  endtask

  task automatic write_center(logic [AddrW-1:0] addr, logic signed [CoordBits-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(32 - CoordBits){val[CoordBits-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == clm_pkg::AddrCenterX) cen_x = val;
    else cen_y = val;
  endtask

  // Mostly points near the circle; the rest are arbitrary field values.
  function automatic in_t random_line();
    in_t v;
    int r;
    int lo_x, hi_x, lo_y, hi_y;
    v = in_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(9) < 4) return v;
    r = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(400);
    v.radius = r[CoordBits-2:0];
    lo_x = (int'(cen_x) - r < -32768) ? -32768 : int'(cen_x) - r;
    hi_x = (int'(cen_x) + r > 32767) ? 32767 : int'(cen_x) + r;
    lo_y = (int'(cen_y) - r < -32768) ? -32768 : int'(cen_y) - r;
    hi_y = (int'(cen_y) + r > 32767) ? 32767 : int'(cen_y) + r;
    v.first_x = CoordBits'(lo_x + $urandom_range(hi_x - lo_x));
    v.first_y = CoordBits'(lo_y + $urandom_range(hi_y - lo_y));
    v.second_x = CoordBits'(lo_x + $urandom_range(hi_x - lo_x));
    v.second_y = CoordBits'(lo_y + $urandom_range(hi_y - lo_y));
    return v;
  endfunction

  task automatic random_phase(int n);
    out_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      send_request(random_line(), 1'b0, none);
      if (i == n / 2 && $urandom_range(1)) drain_pipeline();
    end
  endtask

  initial begin
    row_t rows[$];
    out_t miss;
    miss = '0;
    // Coincident points, a line missing the circle, a tangent and a vertical chord.
    rows = {rows, row_t'{in_t'({16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd0}), 1'b1, miss}};
    rows = {rows, row_t'{in_t'({16'sd100, 16'sd100, 16'sd100, 16'sd100, 15'd50}), 1'b1, miss}};
    rows = {rows, row_t'{in_t'({-16'sd10, 16'sd1000, 16'sd10, 16'sd1000, 15'd5}), 1'b1, miss}};
    rows = {rows, row_t'{in_t'({-16'sd10, 16'sd5, 16'sd10, 16'sd5, 15'd5}), 1'b1,
                         out_t'({16'sd0, 16'sd5, 1'b1})}};
    rows = {rows, row_t'{in_t'({16'sd0, -16'sd10, 16'sd0, 16'sd10, 15'd100}), 1'b1,
                         out_t'({16'sd0, -16'sd100, 1'b1})}};
    rows = {rows, row_t'{in_t'({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 15'h7fff}),
                         1'b0, miss}};
    rows = {rows, row_t'{in_t'({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 15'd0}),
                         1'b0, miss}};
    rows = {rows, row_t'{in_t'({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 15'h7fff}),
                         1'b0, miss}};
    rows = {rows, row_t'{in_t'({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 15'h7fff}),
                         1'b0, miss}};
    rows = {rows, row_t'{in_t'({16'sd0, 16'sd0, 16'sd1, 16'sd0, 15'h7fff}), 1'b0, miss}};
    rows = {rows, row_t'{in_t'({-16'sd300, 16'sd0, 16'sd300, 16'sd1, 15'd200}), 1'b0, miss}};
    rows = {rows, row_t'{in_t'({16'sd50, 16'sd7, -16'sd40, -16'sd90, 15'd120}), 1'b0, miss}};
    rows = {rows, row_t'{in_t'({-16'sd1, -16'sd1, 16'sd1, 16'sd1, 15'd1}), 1'b0, miss}};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        3: begin idle_pct = 7;  stall_pct = 7;  end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      random_phase(ItemsPerPhase);
      drain_pipeline();
      case (ph)
        0: begin
          write_center(clm_pkg::AddrCenterX, 16'sh7fff);
          write_center(clm_pkg::AddrCenterY, 16'sh8000);
        end
        1: begin
          write_center(clm_pkg::AddrCenterX, 16'sh8000);
          write_center(clm_pkg::AddrCenterY, 16'sh7fff);
        end
        2: begin
          write_center(clm_pkg::AddrCenterX, CoordBits'($urandom));
          write_center(clm_pkg::AddrCenterY, CoordBits'($urandom));
        end
        3: begin
          write_center(clm_pkg::AddrCenterX, 16'sd0);
          write_center(clm_pkg::AddrCenterY, 16'sd0);
        end
        default: ;
      endcase
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
